FILE: src/ccbd_pkg.sv
// ccbd_pkg: shared types and constants for the click classifier bar display.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ccbd_pkg;

    localparam int unsigned TICK_W   = 32;
    localparam int unsigned TMO_W    = 16;
    localparam int unsigned BAR_W    = 8;
    localparam int unsigned GEST_W   = 3;
    localparam int unsigned S_DATA_W = 40;   // 1 + 32 bits, padded to whole bytes
    localparam int unsigned M_DATA_W = 24;   // 8 + 8 + 3 bits, padded to whole bytes
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned APB_DW   = 32;

    localparam logic [TMO_W-1:0] C_TIMEOUT_RESET = 16'd200;

    localparam logic [BAR_W-1:0] C_LEAD_BIT    = 8'h80;
    localparam logic [BAR_W-1:0] C_BAR_FULL    = 8'hFF;
    localparam logic [BAR_W-1:0] C_BAR_EMPTY   = 8'h00;
    localparam logic [BAR_W-1:0] C_SL_PATTERN  = 8'hFC;
    localparam logic [BAR_W-1:0] C_DRAIN_EMPTY = 8'hFE;

    // Register map (byte addresses)
    localparam logic [APB_AW-1:0] ADDR_TIMEOUT = 3'd0;

    // Gesture codes on the result word
    typedef enum logic [GEST_W-1:0] {
        G_NONE        = 3'd0,
        G_SHORT       = 3'd1,
        G_LONG        = 3'd2,
        G_SHORT_SHORT = 3'd3,
        G_SHORT_LONG  = 3'd4,
        G_LONG_SHORT  = 3'd5,
        G_LONG_LONG   = 3'd6
    } t_gesture;

    // Bar update requested by the click machine
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_SHORT,
        ACT_LONG,
        ACT_SS,
        ACT_SL,
        ACT_LS,
        ACT_LL
    } t_action;

endpackage

FILE: src/ccbd_fsm.sv
// ccbd_fsm: nine-state click machine with press/release/timeout events.
// Depends on ccbd_pkg. Holds the state and the timestamp of the last edge.
`timescale 1ns / 1ps

module ccbd_fsm
    import ccbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,      // word consumed this cycle
    input  logic              i_pressed,
    input  logic [TICK_W-1:0] i_now,
    input  logic [TMO_W-1:0]  i_timeout,
    output t_action           o_action
);

    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_DOWN1    = 4'd1,   // first press, not yet long
        ST_HELD1    = 4'd2,   // first press held long
        ST_UP1      = 4'd3,   // released after short press
        ST_UPLONG   = 4'd4,   // released after long press
        ST_DOWN_S2  = 4'd5,   // second press after short
        ST_HELD_S2  = 4'd6,
        ST_DOWN_L2  = 4'd7,   // second press after long
        ST_HELD_L2  = 4'd8
    } t_click_state;

    t_click_state       r_state, n_state;
    logic [TICK_W-1:0]  r_stamp;
    logic               n_stamp_en;
    logic [TICK_W-1:0]  elapsed;
    logic               timed;
    logic               tmo;

    assign elapsed = i_now - r_stamp;

    always_comb begin
        case (r_state)
            ST_DOWN1, ST_UP1, ST_UPLONG, ST_DOWN_S2, ST_DOWN_L2: timed = 1'b1;
            default: timed = 1'b0;
        endcase
    end

    assign tmo = timed && (elapsed >= {{(TICK_W-TMO_W){1'b0}}, i_timeout});

    always_comb begin
        n_state    = ST_IDLE;
        n_stamp_en = 1'b0;
        o_action   = ACT_NONE;
        case (r_state)
            ST_DOWN1: begin
                if (tmo)            n_state = ST_HELD1;
                else if (i_pressed) n_state = ST_DOWN1;
                else begin
                    n_state    = ST_UP1;
                    n_stamp_en = 1'b1;
                end
            end
            ST_HELD1: begin
                if (i_pressed) n_state = ST_HELD1;
                else begin
                    n_state    = ST_UPLONG;
                    n_stamp_en = 1'b1;
                end
            end
            ST_UP1: begin
                if (tmo) begin
                    n_state  = ST_IDLE;
                    o_action = ACT_SHORT;
                end else if (i_pressed) begin
                    n_state    = ST_DOWN_S2;
                    n_stamp_en = 1'b1;
                end else n_state = ST_UP1;
            end
            ST_UPLONG: begin
                if (tmo) begin
                    n_state  = ST_IDLE;
                    o_action = ACT_LONG;
                end else if (i_pressed) begin
                    n_state    = ST_DOWN_L2;
                    n_stamp_en = 1'b1;
                end else n_state = ST_UPLONG;
            end
            ST_DOWN_S2: begin
                if (tmo)            n_state = ST_HELD_S2;
                else if (i_pressed) n_state = ST_DOWN_S2;
                else begin
                    n_state  = ST_IDLE;
                    o_action = ACT_SS;
                end
            end
            ST_HELD_S2: begin
                if (i_pressed) n_state = ST_HELD_S2;
                else begin
                    n_state  = ST_IDLE;
                    o_action = ACT_SL;
                end
            end
            ST_DOWN_L2: begin
                if (tmo)            n_state = ST_HELD_L2;
                else if (i_pressed) n_state = ST_DOWN_L2;
                else begin
                    n_state  = ST_IDLE;
                    o_action = ACT_LS;
                end
            end
            ST_HELD_L2: begin
                if (i_pressed) n_state = ST_HELD_L2;
                else begin
                    n_state  = ST_IDLE;
                    o_action = ACT_LL;
                end
            end
            default: begin
                // idle, and any stray code behaves as idle
                if (i_pressed) begin
                    n_state    = ST_DOWN1;
                    n_stamp_en = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_stamp <= '0;
        end else if (i_advance) begin
            r_state <= n_state;
            if (n_stamp_en) r_stamp <= i_now;
        end
    end

endmodule

FILE: src/ccbd_bar.sv
// ccbd_bar: bar pattern update per gesture, holds fill and both bar rows.
// Depends on ccbd_pkg; driven by the action from ccbd_fsm.
`timescale 1ns / 1ps

module ccbd_bar
    import ccbd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  t_action          i_action,
    output logic [BAR_W-1:0] o_bar_one,    // value for this word
    output logic [BAR_W-1:0] o_bar_two,
    output t_gesture         o_gesture
);

    logic [BAR_W-1:0] r_fill, n_fill;
    logic             r_second, n_second;
    logic [BAR_W-1:0] r_one, r_two;
    logic [BAR_W-1:0] lead_fill;
    logic [BAR_W-1:0] shl_fill;

    assign lead_fill = (r_fill >> 1) + C_LEAD_BIT;
    assign shl_fill  = r_fill << 1;

    always_comb begin
        n_fill    = r_fill;
        n_second  = r_second;
        o_bar_one = r_one;
        o_bar_two = r_two;
        o_gesture = G_NONE;
        case (i_action)
            ACT_SHORT: begin
                o_gesture = G_SHORT;
                n_fill    = lead_fill;
                if (!r_second) begin
                    o_bar_one = lead_fill;
                    o_bar_two = C_BAR_EMPTY;
                    if (lead_fill == C_BAR_FULL) begin
                        n_second = 1'b1;
                        n_fill   = C_BAR_EMPTY;
                    end
                end else begin
                    o_bar_one = C_BAR_FULL;
                    o_bar_two = lead_fill;
                end
            end
            ACT_LONG: begin
                o_gesture = G_LONG;
                n_second  = 1'b1;
                n_fill    = C_BAR_EMPTY;
                o_bar_one = C_BAR_FULL;
                o_bar_two = C_BAR_EMPTY;
            end
            ACT_SS: begin
                o_gesture = G_SHORT_SHORT;
                if (r_second && r_fill == C_BAR_EMPTY) begin
                    // drained second bar: back to first bar, one LED off
                    n_second  = 1'b0;
                    n_fill    = C_DRAIN_EMPTY;
                    o_bar_one = C_DRAIN_EMPTY;
                    o_bar_two = C_BAR_EMPTY;
                end else if (r_second) begin
                    n_fill    = shl_fill;
                    o_bar_one = C_BAR_FULL;
                    o_bar_two = shl_fill;
                end else begin
                    n_fill    = shl_fill;
                    o_bar_one = shl_fill;
                    o_bar_two = C_BAR_EMPTY;
                end
            end
            ACT_SL: begin
                o_gesture = G_SHORT_LONG;
                n_fill    = C_SL_PATTERN;
                n_second  = 1'b0;
                o_bar_one = C_SL_PATTERN;
                o_bar_two = C_BAR_EMPTY;
            end
            ACT_LS: begin
                o_gesture = G_LONG_SHORT;
                n_fill    = C_BAR_FULL;
                n_second  = 1'b1;
                o_bar_one = C_BAR_FULL;
                o_bar_two = C_BAR_FULL;
            end
            ACT_LL: begin
                o_gesture = G_LONG_LONG;
                n_fill    = C_BAR_EMPTY;
                n_second  = 1'b0;
                o_bar_one = C_BAR_EMPTY;
                o_bar_two = C_BAR_EMPTY;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_second <= 1'b0;
            r_one    <= '0;
            r_two    <= '0;
        end else if (i_advance) begin
            r_fill   <= n_fill;
            r_second <= n_second;
            r_one    <= o_bar_one;
            r_two    <= o_bar_two;
        end
    end

endmodule

FILE: src/click_classifier_bar_display_unit.sv
// click_classifier_bar_display_unit: top level, stream ports, APB register,
// input and result registers. Depends on ccbd_pkg, ccbd_fsm and ccbd_bar.
`timescale 1ns / 1ps

// Channel    | Direction | Ports                         | Word
// -----------+-----------+-------------------------------+---------------------------
// poll in    | slave     | i_s_tvalid/o_s_tready/i_s_tdata | button_pressed, now_tick
// result out | master    | o_m_tvalid/i_m_tready/o_m_tdata | bar_one, bar_two, gesture
// config     | APB       | psel/penable/pwrite/paddr/...   | timeout_ticks at 0x0
//
// One word per cycle sustained while i_m_tready is high. Input register
// then result register, with the click machine and bar update between them.
// Synchronous active-low reset: idle state, stamp 0, bars empty, timeout 200.
// A stalled result holds the output register; the input register still
// takes a word while it is empty, so each side can stall one word deep.

module click_classifier_bar_display_unit
    import ccbd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,   // [0] button_pressed, [32:1] now_tick

    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,   // [7:0] bar_one, [15:8] bar_two,
                                             // [18:16] gesture

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    // config register
    logic [TMO_W-1:0]  r_timeout;

    // input register
    logic              r_in_valid;
    logic              r_pressed;
    logic [TICK_W-1:0] r_now;

    // result register
    logic              r_out_valid;
    logic [BAR_W-1:0]  r_bar_one;
    logic [BAR_W-1:0]  r_bar_two;
    t_gesture          r_gesture;

    logic              advance;
    logic              s_accept;
    t_action           action;
    logic [BAR_W-1:0]  n_bar_one;
    logic [BAR_W-1:0]  n_bar_two;
    t_gesture          n_gesture;

    // The input word moves on when the result register is free or draining.
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TIMEOUT) ?
                    {{(APB_DW-TMO_W){1'b0}}, r_timeout} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= C_TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr == ADDR_TIMEOUT)) begin
            r_timeout <= pwdata[TMO_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_pressed <= i_s_tdata[0];
            r_now     <= i_s_tdata[TICK_W:1];
        end
    end

    ccbd_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_pressed (r_pressed),
        .i_now     (r_now),
        .i_timeout (r_timeout),
        .o_action  (action)
    );

    ccbd_bar u_bar (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_action  (action),
        .o_bar_one (n_bar_one),
        .o_bar_two (n_bar_two),
        .o_gesture (n_gesture)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_bar_one <= n_bar_one;
            r_bar_two <= n_bar_two;
            r_gesture <= n_gesture;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_DATA_W-2*BAR_W-GEST_W){1'b0}}, r_gesture, r_bar_two, r_bar_one};

endmodule
